### src/twfc_pkg.sv
// Shared constants, word layouts and input and result types for the tile window fetch controller.
package twfc_pkg;

  localparam int WORDS_PER_LINE = 8;
  localparam int LINES_PER_TILE = 32;
  localparam int SETTLE_TICKS   = 3;
  localparam int VALID_TICKS    = 256;

  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 32;
  localparam int COORD_W  = 16;
  localparam int STRIDE_W = 16;

  localparam int WORD_CNT_W = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
  localparam int LINE_CNT_W = $clog2(LINES_PER_TILE + 1);
  localparam int WAIT_MAX   = (SETTLE_TICKS > VALID_TICKS + 1) ? SETTLE_TICKS
                                                                : VALID_TICKS + 1;
  localparam int WAIT_CNT_W = $clog2(WAIT_MAX + 1);

  // bytes to step back from the end of a line to its start
  localparam logic [ADDR_W-1:0] LINE_BACK = ADDR_W'(4 * (WORDS_PER_LINE - 1));
  localparam logic [ADDR_W-1:0] WORD_BYTES = ADDR_W'(4);

  // stream word layouts (payload bits, padded to whole bytes)
  localparam int IN_BITS   = 1 + COORD_W + COORD_W + 1 + DATA_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 1 + 1 + ADDR_W + 1 + DATA_W + 1 + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE = 1'b1;

  localparam logic [ADDR_W-1:0]   FRAME_BASE_RST  = 32'h0000_0800;
  localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST = 16'd640;

  typedef struct packed {
    logic                tile_req;
    logic [COORD_W-1:0]  window_x;
    logic [COORD_W-1:0]  window_y;
    logic                bus_ack;
    logic [DATA_W-1:0]   bus_read_data;
  } twfc_in_t;

  typedef struct packed {
    logic                bus_cycle;
    logic                bus_strobe;
    logic [ADDR_W-1:0]   bus_address;
    logic                buffer_write;
    logic [DATA_W-1:0]   buffer_data;
    logic                ask_for_xy;
    logic                valid_res;
  } twfc_res_t;

endpackage

### src/tile_window_fetch_controller.sv
// Top level: configuration registers, stream handshake and word packing.
// Latency: a result word is presented on the cycle after its input word is accepted.
// Throughput: one word per cycle while out_tready is high; each input yields exactly one result word.
// The result register frees in the same cycle it is taken, so out_tready alone sets the rate.
// Reset (rst_n low, synchronous): sequencer idle waiting for a tile, all flags and
// the held address/data cleared, frame base 0x800, line stride 640.
module tile_window_fetch_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tile_req, window_x, window_y, bus_ack, bus_read_data (from bit 0 up)
  input  logic [twfc_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // bus_cycle, bus_strobe, bus_address, buffer_write, buffer_data, ask_for_xy,
  // valid_res (from bit 0 up)
  output logic [twfc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [twfc_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [twfc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import twfc_pkg::*;

  logic [ADDR_W-1:0]   frame_base_r;
  logic [STRIDE_W-1:0] line_stride_r;
  logic                out_valid_r, out_valid_nxt;
  logic                step;
  twfc_in_t            item;
  twfc_res_t           res;

  // unpack input word
  assign item.tile_req      = in_tdata[0];
  assign item.window_x      = in_tdata[COORD_W:1];
  assign item.window_y      = in_tdata[2*COORD_W:COORD_W+1];
  assign item.bus_ack       = in_tdata[2*COORD_W+1];
  assign item.bus_read_data = in_tdata[2*COORD_W+1+DATA_W:2*COORD_W+2];

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      frame_base_r  <= FRAME_BASE_RST;
      line_stride_r <= LINE_STRIDE_RST;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FRAME_BASE:  frame_base_r  <= cfg_wdata[ADDR_W-1:0];
          CFG_LINE_STRIDE: line_stride_r <= cfg_wdata[STRIDE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  twfc_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (item),
    .frame_base  (frame_base_r),
    .line_stride (line_stride_r),
    .res         (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}},
                       res.valid_res,
                       res.ask_for_xy,
                       res.buffer_data,
                       res.buffer_write,
                       res.bus_address,
                       res.bus_strobe,
                       res.bus_cycle};

endmodule

### src/twfc_seq.sv
// Fetch sequencer: phase, address and counters, advanced once per accepted word.
module twfc_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  twfc_pkg::twfc_in_t              item,
  input  logic [twfc_pkg::ADDR_W-1:0]     frame_base,
  input  logic [twfc_pkg::STRIDE_W-1:0]   line_stride,
  output twfc_pkg::twfc_res_t             res
);
  import twfc_pkg::*;

  typedef enum logic [2:0] {
    PH_NEW_TILE = 3'd0,
    PH_START    = 3'd1,
    PH_READ     = 3'd2,
    PH_ENDLINE  = 3'd3,
    PH_END      = 3'd4,
    PH_SETTLE   = 3'd5,
    PH_VALID    = 3'd6
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [ADDR_W-1:0]     fetch_addr_r, fetch_addr_nxt;
  logic [WORD_CNT_W-1:0] word_cnt_r, word_cnt_nxt;
  logic [LINE_CNT_W-1:0] line_cnt_r, line_cnt_nxt;
  logic [WAIT_CNT_W-1:0] wait_cnt_r, wait_cnt_nxt;
  logic                  wr_pend_r, wr_pend_nxt;
  logic [DATA_W-1:0]     held_word_r, held_word_nxt;
  logic [ADDR_W-1:0]     held_addr_r, held_addr_nxt;
  logic                  cyc_r, cyc_nxt;
  logic                  stb_r, stb_nxt;
  logic                  write_r, write_nxt;
  logic                  ask_r, ask_nxt;
  logic                  valid_r, valid_nxt;

  logic [ADDR_W-1:0]     row_offset;
  logic [ADDR_W-1:0]     start_addr;
  logic [LINE_CNT_W-1:0] line_cnt_inc;
  logic [WAIT_CNT_W-1:0] wait_cnt_inc;

  assign row_offset   = {{(ADDR_W-STRIDE_W){1'b0}}, line_stride} *
                        {{(ADDR_W-COORD_W){1'b0}}, item.window_y};
  assign start_addr   = frame_base + {{(ADDR_W-COORD_W){1'b0}}, item.window_x[COORD_W-1:2], 2'b00}
                        + row_offset;
  assign line_cnt_inc = line_cnt_r + 1'b1;
  assign wait_cnt_inc = wait_cnt_r + 1'b1;

  always_comb begin
    phase_nxt      = phase_r;
    fetch_addr_nxt = fetch_addr_r;
    word_cnt_nxt   = word_cnt_r;
    line_cnt_nxt   = line_cnt_r;
    wait_cnt_nxt   = wait_cnt_r;
    wr_pend_nxt    = wr_pend_r;
    held_word_nxt  = held_word_r;

    case (phase_r)
      PH_START: begin
        word_cnt_nxt   = '0;
        line_cnt_nxt   = '0;
        fetch_addr_nxt = start_addr;
        wr_pend_nxt    = 1'b0;
        phase_nxt      = PH_READ;
      end
      PH_READ: begin
        if (item.bus_ack) begin
          held_word_nxt = item.bus_read_data;
          wr_pend_nxt   = 1'b1;
          if (word_cnt_r == WORD_CNT_W'(WORDS_PER_LINE - 1)) begin
            // back to the line start, then down one stride
            word_cnt_nxt   = '0;
            fetch_addr_nxt = fetch_addr_r + {{(ADDR_W-STRIDE_W){1'b0}}, line_stride} - LINE_BACK;
            line_cnt_nxt   = line_cnt_inc;
            phase_nxt      = (line_cnt_inc >= LINE_CNT_W'(LINES_PER_TILE)) ? PH_END : PH_ENDLINE;
          end else begin
            word_cnt_nxt   = word_cnt_r + 1'b1;
            fetch_addr_nxt = fetch_addr_r + WORD_BYTES;
          end
        end else begin
          wr_pend_nxt = 1'b0;
        end
      end
      PH_ENDLINE: begin
        wr_pend_nxt = 1'b0;
        phase_nxt   = PH_READ;
      end
      PH_END: begin
        wr_pend_nxt  = 1'b0;
        wait_cnt_nxt = '0;
        phase_nxt    = PH_SETTLE;
      end
      PH_SETTLE: begin
        wait_cnt_nxt = wait_cnt_inc;
        if (wait_cnt_inc >= WAIT_CNT_W'(SETTLE_TICKS)) begin
          wait_cnt_nxt = '0;
          phase_nxt    = PH_VALID;
        end
      end
      PH_VALID: begin
        wait_cnt_nxt = wait_cnt_inc;
        if (wait_cnt_inc >= WAIT_CNT_W'(VALID_TICKS + 1)) begin
          phase_nxt = PH_NEW_TILE;
        end
      end
      default: begin
        phase_nxt = item.tile_req ? PH_START : PH_NEW_TILE;
      end
    endcase
  end

  // output flags follow the phase being entered
  always_comb begin
    held_addr_nxt = held_addr_r;
    cyc_nxt       = cyc_r;
    stb_nxt       = stb_r;
    write_nxt     = write_r;
    ask_nxt       = ask_r;
    valid_nxt     = valid_r;

    case (phase_nxt)
      PH_START: begin
        valid_nxt = 1'b0;
      end
      PH_READ: begin
        cyc_nxt       = 1'b1;
        stb_nxt       = 1'b1;
        held_addr_nxt = fetch_addr_nxt;
        write_nxt     = wr_pend_nxt;
      end
      PH_ENDLINE: begin
        cyc_nxt   = 1'b0;
        stb_nxt   = 1'b0;
        write_nxt = wr_pend_nxt;
      end
      PH_END: begin
        cyc_nxt   = 1'b0;
        stb_nxt   = 1'b0;
        write_nxt = wr_pend_nxt;
        ask_nxt   = 1'b1;
      end
      PH_SETTLE: begin
        ask_nxt   = 1'b0;
        write_nxt = 1'b0;
      end
      PH_VALID: begin
        valid_nxt = 1'b1;
      end
      default: begin
        valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_NEW_TILE;
      fetch_addr_r <= '0;
      word_cnt_r   <= '0;
      line_cnt_r   <= '0;
      wait_cnt_r   <= '0;
      wr_pend_r    <= 1'b0;
      held_word_r  <= '0;
      held_addr_r  <= '0;
      cyc_r        <= 1'b0;
      stb_r        <= 1'b0;
      write_r      <= 1'b0;
      ask_r        <= 1'b0;
      valid_r      <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      fetch_addr_r <= fetch_addr_nxt;
      word_cnt_r   <= word_cnt_nxt;
      line_cnt_r   <= line_cnt_nxt;
      wait_cnt_r   <= wait_cnt_nxt;
      wr_pend_r    <= wr_pend_nxt;
      held_word_r  <= held_word_nxt;
      held_addr_r  <= held_addr_nxt;
      cyc_r        <= cyc_nxt;
      stb_r        <= stb_nxt;
      write_r      <= write_nxt;
      ask_r        <= ask_nxt;
      valid_r      <= valid_nxt;
    end
  end

  assign res.bus_cycle    = cyc_r;
  assign res.bus_strobe   = stb_r;
  assign res.bus_address  = held_addr_r;
  assign res.buffer_write = write_r;
  assign res.buffer_data  = held_word_r;
  assign res.ask_for_xy   = ask_r;
  assign res.valid_res    = valid_r;

  a_ask_in_end: assert property (@(posedge clk) disable iff (!rst_n)
    ask_r |-> phase_r == PH_END)
    else $error("ask_for_xy high outside the end phase");

  a_valid_in_valid: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> phase_r == PH_VALID)
    else $error("valid_res high outside the output period");

  a_addr_moves_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(held_addr_r) |-> phase_r == PH_READ)
    else $error("bus address changed outside the read phase");

  a_word_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    word_cnt_r <= WORD_CNT_W'(WORDS_PER_LINE - 1))
    else $error("word counter past end of line");

  a_bus_idle_outside_read: assert property (@(posedge clk) disable iff (!rst_n)
    cyc_r |-> (phase_r == PH_READ) && !ask_r && !valid_r)
    else $error("bus cycle active outside the read phase");

endmodule
